[hdl/k_smallest_heap_select_unit_assert.svh]
// assertion macros for the k smallest heap select unit
// included by the top level; needs no other file
`ifndef K_SMALLEST_HEAP_SELECT_UNIT_ASSERT_SVH
`define K_SMALLEST_HEAP_SELECT_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// antecedent implies consequent in the same cycle
`define KSHS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("heap select check failed");
// antecedent implies consequent in the next cycle
`define KSHS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("heap select check failed");
`else
`define KSHS_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`define KSHS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

[hdl/kshs_pkg.sv]
// shared types and constants of the k smallest heap select unit
// used by kshs_heap_mem and k_smallest_heap_select_unit; depends on nothing
package kshs_pkg;

  localparam int unsigned DIST_W            = 32;
  localparam int unsigned NB_W              = 31;
  localparam int unsigned CFG_W             = 7;
  localparam int unsigned TDATA_W           = 64;
  localparam int unsigned MAX_NEIGHBORS_DEF = 64;

  // k after reset
  localparam logic [CFG_W-1:0] K_RESET = 7'd64;

  // mode carried in tuser
  localparam logic MODE_OFFER  = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // one heap slot
  typedef struct packed {
    logic              filled;
    logic [NB_W-1:0]   neighbor;
    logic [DIST_W-1:0] distance;
  } entry_t;

  // value of a slot that holds no candidate
  localparam entry_t EMPTY_ENTRY = '{filled: 1'b0, neighbor: '0, distance: '1};

  // memory control strobes
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clear;
  } mem_ctl_t;

endpackage

[hdl/kshs_heap_mem.sv]
// heap slot memory: one write port, two registered read ports, per-slot valid bits
// depends on kshs_pkg
module kshs_heap_mem #(
  parameter int unsigned DEPTH = kshs_pkg::MAX_NEIGHBORS_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kshs_pkg::mem_ctl_t ctl_i,
  input  logic [AW-1:0]      wr_addr_i,
  input  kshs_pkg::entry_t   wr_data_i,
  input  logic [AW-1:0]      rd_addr_a_i,
  input  logic [AW-1:0]      rd_addr_b_i,
  output kshs_pkg::entry_t   rd_data_a_o,
  output kshs_pkg::entry_t   rd_data_b_o
);

  kshs_pkg::entry_t mem_q [DEPTH];
  logic [DEPTH-1:0] valid_q, valid_d;
  kshs_pkg::entry_t data_a_q, data_b_q;
  logic             hit_a_q, hit_b_q;
  logic             fwd_a, fwd_b;

  // write goes straight to a read of the same slot
  assign fwd_a = ctl_i.wr_en && (wr_addr_i == rd_addr_a_i);
  assign fwd_b = ctl_i.wr_en && (wr_addr_i == rd_addr_b_i);

  // storage array
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // valid bits: set on write, all dropped on clear
  always_comb begin
    valid_d = valid_q;
    if (ctl_i.wr_en) begin
      valid_d[wr_addr_i] = 1'b1;
    end
    if (ctl_i.clear) begin
      valid_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      hit_a_q <= 1'b0;
      hit_b_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (ctl_i.rd_en) begin
        hit_a_q <= valid_q[rd_addr_a_i] || fwd_a;
        hit_b_q <= valid_q[rd_addr_b_i] || fwd_b;
      end
    end
  end

  // registered read data, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (ctl_i.rd_en) begin
      data_a_q <= fwd_a ? wr_data_i : mem_q[rd_addr_a_i];
      data_b_q <= fwd_b ? wr_data_i : mem_q[rd_addr_b_i];
    end
  end

  // a slot never written since the last clear reads as empty
  assign rd_data_a_o = hit_a_q ? data_a_q : kshs_pkg::EMPTY_ENTRY;
  assign rd_data_b_o = hit_b_q ? data_b_q : kshs_pkg::EMPTY_ENTRY;

endmodule

[hdl/k_smallest_heap_select_unit.sv]
// top level of the k smallest heap select unit: sift and heap sort sequencer
// depends on kshs_pkg, kshs_heap_mem and k_smallest_heap_select_unit_assert.svh
//
//  channel   direction  word                                   handshake
//  cfg       in         k (7 bits)                             cfg_valid_i / cfg_ready_o
//  s_axis    in         tdata distance+neighbor, tuser mode    tvalid / tready
//  m_axis    out        tdata distance+neighbor, tuser found,  tvalid / tready
//                       tlast on the final sorted word
//
// an offer below the root, when k is above one, reads the root and then sifts down one heap
// level per step; each heap level is two reads and one write on the slot memory; any other
// offer ends once the root is read
// a finish sorts the heap with swap and sift steps, then drains one word per cycle while
// m_axis_tready is high
// reset clears the per-slot valid bits at once; no clearing pass is needed
// results wait in an output register; a stalled drain holds the read data in place
`include "k_smallest_heap_select_unit_assert.svh"

module k_smallest_heap_select_unit #(
  parameter int unsigned MAX_NEIGHBORS = kshs_pkg::MAX_NEIGHBORS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // configuration write
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [kshs_pkg::CFG_W-1:0]   cfg_data_i,
  // input stream
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [kshs_pkg::TDATA_W-1:0] s_axis_tdata,  // distance[31:0], neighbor[62:32]
  input  logic                         s_axis_tuser,  // mode
  // output stream
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [kshs_pkg::TDATA_W-1:0] m_axis_tdata,  // out_distance[31:0], out_neighbor[62:32]
  output logic                         m_axis_tuser,  // found
  output logic                         m_axis_tlast
);

  localparam int unsigned AW = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int unsigned KW = $clog2(MAX_NEIGHBORS + 1);
  localparam int unsigned CW = $clog2(2 * MAX_NEIGHBORS + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_ROOT  = 6'b000010,
    ST_SIFT  = 6'b000100,
    ST_PUT   = 6'b001000,
    ST_SWAP  = 6'b010000,
    ST_DRAIN = 6'b100000
  } state_e;

  state_e                     state_q, state_d;
  logic [kshs_pkg::CFG_W-1:0] k_q;
  logic [kshs_pkg::CFG_W-1:0] k_sat;
  logic [KW-1:0]              k_new;
  logic [KW-1:0]              k_act_q, k_act_d;
  logic [KW-1:0]              lim_q, lim_d;
  logic [KW-1:0]              end_q, end_d;
  logic [AW-1:0]              pos_q, pos_d;
  logic [AW-1:0]              drain_q, drain_d;
  logic                       sort_q, sort_d;
  kshs_pkg::entry_t           x_q, x_d;

  // memory interface
  kshs_pkg::mem_ctl_t         mem_ctl;
  logic [AW-1:0]              wr_addr, rd_addr_a, rd_addr_b;
  kshs_pkg::entry_t           wr_data, rd_a, rd_b;

  // sift decision
  logic [CW-1:0]              cl, cr;
  logic                       cur_r_ok, pick_r, move, l_gt, r_big;
  logic [kshs_pkg::DIST_W-1:0] big_d;
  kshs_pkg::entry_t           ch;
  logic [AW-1:0]              ch_idx;

  // children of the next position
  logic [AW-1:0]              np;
  logic [KW-1:0]              nlim;
  logic [CW-1:0]              nl, nr;
  logic                       n_has_l, n_has_r;

  // step control
  logic                       sift_done, start_iter;
  logic [KW-1:0]              cur_end, end_m1;
  logic                       out_free, out_load, out_last;

  // output register
  logic                       m_valid_q;
  kshs_pkg::entry_t           out_q;
  logic                       last_q;

  // ------------------------------------------------------------------
  // memory
  kshs_heap_mem #(
    .DEPTH (MAX_NEIGHBORS),
    .AW    (AW)
  ) u_mem (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (mem_ctl),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_a),
    .rd_data_b_o (rd_b)
  );

  // ------------------------------------------------------------------
  // configuration register and active k
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q <= kshs_pkg::K_RESET;
    end else if (cfg_valid_i) begin
      k_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (k_q == '0) begin
      k_sat = kshs_pkg::CFG_W'(1);
    end else if (k_q > kshs_pkg::CFG_W'(MAX_NEIGHBORS)) begin
      k_sat = kshs_pkg::CFG_W'(MAX_NEIGHBORS);
    end else begin
      k_sat = k_q;
    end
  end

  assign k_new = KW'(k_sat);

  // ------------------------------------------------------------------
  // child selection at the current position; rd_a is left, rd_b is right
  assign cl       = (CW'(pos_q) << 1) + CW'(1);
  assign cr       = cl + CW'(1);
  assign cur_r_ok = cr < CW'(lim_q);

  always_comb begin
    l_gt  = rd_a.distance > x_q.distance;
    big_d = l_gt ? rd_a.distance : x_q.distance;
    r_big = cur_r_ok && (rd_b.distance > big_d);
    if (sort_q) begin
      // sort: larger of node and children wins, ties stay put or go left
      pick_r = r_big;
      move   = l_gt || r_big;
    end else begin
      // offer: right child wins ties, moves up only when above the new key
      pick_r = cur_r_ok && (rd_a.distance <= rd_b.distance);
      move   = (pick_r ? rd_b.distance : rd_a.distance) > x_q.distance;
    end
    ch     = pick_r ? rd_b : rd_a;
    ch_idx = pick_r ? cr[AW-1:0] : cl[AW-1:0];
  end

  // children of the position the sift goes to next
  always_comb begin
    np   = '0;
    nlim = lim_q;
    if (state_q == ST_SIFT) begin
      np = ch_idx;
    end
    if (state_q == ST_SWAP) begin
      nlim = end_q;
    end
  end

  assign nl      = (CW'(np) << 1) + CW'(1);
  assign nr      = nl + CW'(1);
  assign n_has_l = nl < CW'(nlim);
  assign n_has_r = nr < CW'(nlim);

  assign out_free = !m_valid_q || m_axis_tready;
  assign end_m1   = cur_end - KW'(1);

  // ------------------------------------------------------------------
  // sequencer
  always_comb begin
    state_d    = state_q;
    k_act_d    = k_act_q;
    lim_d      = lim_q;
    end_d      = end_q;
    pos_d      = pos_q;
    drain_d    = drain_q;
    sort_d     = sort_q;
    x_d        = x_q;
    mem_ctl    = '0;
    wr_addr    = pos_q;
    wr_data    = x_q;
    rd_addr_a  = '0;
    rd_addr_b  = '0;
    sift_done  = 1'b0;
    start_iter = 1'b0;
    cur_end    = end_q;
    out_load   = 1'b0;
    out_last   = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          k_act_d = k_new;
          lim_d   = k_new;
          sort_d  = (s_axis_tuser == kshs_pkg::MODE_FINISH);
          x_d     = '{filled: 1'b1,
                      neighbor: s_axis_tdata[kshs_pkg::DIST_W +: kshs_pkg::NB_W],
                      distance: s_axis_tdata[kshs_pkg::DIST_W-1:0]};
          if (s_axis_tuser == kshs_pkg::MODE_OFFER) begin
            // fetch the root
            mem_ctl.rd_en = 1'b1;
            rd_addr_a     = '0;
            state_d       = ST_ROOT;
          end else begin
            start_iter = 1'b1;
            cur_end    = k_new;
          end
        end
      end

      ST_ROOT: begin
        if (x_q.distance < rd_a.distance) begin
          pos_d = '0;
          if (n_has_l) begin
            mem_ctl.rd_en = 1'b1;
            rd_addr_a     = nl[AW-1:0];
            rd_addr_b     = n_has_r ? nr[AW-1:0] : '0;
            state_d       = ST_SIFT;
          end else begin
            // single slot heap: replace the root
            mem_ctl.wr_en = 1'b1;
            wr_addr       = '0;
            state_d       = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end

      ST_SWAP: begin
        // root goes to the end slot, end slot value sifts from the root
        mem_ctl.wr_en = 1'b1;
        wr_addr       = end_q[AW-1:0];
        wr_data       = rd_a;
        x_d           = rd_b;
        pos_d         = '0;
        lim_d         = end_q;
        if (n_has_l) begin
          mem_ctl.rd_en = 1'b1;
          rd_addr_a     = nl[AW-1:0];
          rd_addr_b     = n_has_r ? nr[AW-1:0] : '0;
          state_d       = ST_SIFT;
        end else begin
          state_d = ST_PUT;
        end
      end

      ST_SIFT: begin
        mem_ctl.wr_en = 1'b1;
        if (move) begin
          // child moves up one level
          wr_data = ch;
          pos_d   = ch_idx;
          if (n_has_l) begin
            mem_ctl.rd_en = 1'b1;
            rd_addr_a     = nl[AW-1:0];
            rd_addr_b     = n_has_r ? nr[AW-1:0] : '0;
          end else begin
            state_d = ST_PUT;
          end
        end else begin
          sift_done = 1'b1;
        end
      end

      ST_PUT: begin
        mem_ctl.wr_en = 1'b1;
        sift_done     = 1'b1;
      end

      ST_DRAIN: begin
        if (out_free) begin
          out_load = 1'b1;
          out_last = (KW'(drain_q) + KW'(1)) == k_act_q;
          if (out_last) begin
            mem_ctl.clear = 1'b1;
            state_d       = ST_IDLE;
          end else begin
            drain_d       = drain_q + AW'(1);
            mem_ctl.rd_en = 1'b1;
            rd_addr_a     = drain_q + AW'(1);
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // end of one sift: offers are done, sorting takes its next step
    if (sift_done) begin
      if (sort_q) begin
        start_iter = 1'b1;
      end else begin
        state_d = ST_IDLE;
      end
    end

    // next heap sort step, or the drain once one slot is left
    if (start_iter) begin
      mem_ctl.rd_en = 1'b1;
      if (cur_end <= KW'(1)) begin
        drain_d   = '0;
        rd_addr_a = '0;
        state_d   = ST_DRAIN;
      end else begin
        end_d     = end_m1;
        rd_addr_a = '0;
        rd_addr_b = end_m1[AW-1:0];
        state_d   = ST_SWAP;
      end
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_act_q <= KW'(MAX_NEIGHBORS);
      lim_q   <= '0;
      end_q   <= '0;
      pos_q   <= '0;
      drain_q <= '0;
      sort_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      k_act_q <= k_act_d;
      lim_q   <= lim_d;
      end_q   <= end_d;
      pos_q   <= pos_d;
      drain_q <= drain_d;
      sort_q  <= sort_d;
    end
  end

  // carried key
  always_ff @(posedge clk_i) begin
    x_q <= x_d;
  end

  // ------------------------------------------------------------------
  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q  <= rd_a;
      last_q <= out_last;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {1'b0, out_q.neighbor, out_q.distance};
  assign m_axis_tuser  = out_q.filled;
  assign m_axis_tlast  = last_q;

  // ------------------------------------------------------------------
  // checks
  `KSHS_ASSERT_IMPLIES(a_sift_pos_in_heap, clk_i, rst_ni, state_q == ST_SIFT, KW'(pos_q) < lim_q)
  `KSHS_ASSERT_IMPLIES(a_write_in_k, clk_i, rst_ni, mem_ctl.wr_en, KW'(wr_addr) < k_act_q)
  `KSHS_ASSERT_IMPLIES(a_drain_in_k, clk_i, rst_ni, state_q == ST_DRAIN, KW'(drain_q) < k_act_q)
  `KSHS_ASSERT_NEXT(a_clear_then_idle, clk_i, rst_ni, mem_ctl.clear, state_q == ST_IDLE)

endmodule
